// File: hw/rtl/svd_pkg.sv
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types, status codes and the byte limit table for the signed
// variable-length integer decoder.
// ----------------------------------------------------------------------------
package svd_pkg;

    localparam int VALUE_W = 64;
    localparam int COUNT_W = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // register indexes
    localparam logic REG_VALUE_SIZE = 1'b0;

    localparam logic [1:0] VALUE_SIZE_RESET = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       buffer_end;
    } svd_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } svd_out_t;

    // most encoded bytes allowed for each value size code
    function automatic logic [COUNT_W-1:0] byte_limit(input logic [1:0] value_size);
        logic [COUNT_W-1:0] lim;
        case (value_size)
            2'd0:    lim = 4'd2;
            2'd1:    lim = 4'd3;
            2'd2:    lim = 4'd5;
            default: lim = 4'd10;
        endcase
        return lim;
    endfunction

endpackage

// File: hw/rtl/signed_varint_decoder.sv
// ----------------------------------------------------------------------------
// signed_varint_decoder
// Decodes a byte stream of signed variable-length integers into 64-bit
// values with a status code.
// ----------------------------------------------------------------------------
//  channel   direction  payload                      handshake
//  in        sink       svd_in_t  {byte_value, end}  in_valid / in_ready
//  out       source     svd_out_t {value, status}    out_valid / out_ready
//  cfg       APB slave  value_size at offset 0x0     psel / penable / pready
//
//  One byte per cycle sustained while no result is stalled; a result passes
//  the input register, then the decode step into the result register.
//  The decode step (shift-or, limit compare, 64-bit negate) is a single step.
//  Reset clears the decode state, both valid flags and sets value_size to 2.
//  A stalled result holds the result register; the input register still
//  drains beats that produce no result.
// ----------------------------------------------------------------------------
module signed_varint_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  svd_pkg::svd_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output svd_pkg::svd_out_t          out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [svd_pkg::ADDR_W-1:0] paddr,
    input  logic [svd_pkg::DATA_W-1:0] pwdata,
    output logic [svd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import svd_pkg::*;

    logic       vsize_hit;
    logic [1:0] value_size_reg;
    logic       s1_valid_reg;
    svd_in_t    s1_data_reg;
    logic       out_valid_reg;
    svd_out_t   out_data_reg;
    logic       s1_take;
    logic       has_result;
    svd_out_t   result;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign vsize_hit = (paddr[2] == REG_VALUE_SIZE);
    assign prdata    = vsize_hit ? {{(DATA_W-2){1'b0}}, value_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_size_reg <= VALUE_SIZE_RESET;
        end
        else if (cfg_write && vsize_hit)
        begin
            value_size_reg <= pwdata[1:0];
        end
    end

    // a beat with no result may leave even while the output is stalled
    assign s1_take  = s1_valid_reg && (!out_valid_reg || out_ready || !has_result);
    assign in_ready = !s1_valid_reg || s1_take;

    svd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_size (value_size_reg),
        .item       (s1_data_reg),
        .take       (s1_take),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_take && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && has_result)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/svd_core.sv
// ----------------------------------------------------------------------------
// svd_core
// Decode state (accumulator, byte count) and the per-byte step logic. The
// result is combinational; the state moves only on a take.
// ----------------------------------------------------------------------------
module svd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      value_size,
    input  svd_pkg::svd_in_t item,
    input  logic            take,
    output logic            has_result,
    output svd_pkg::svd_out_t result
);
    import svd_pkg::*;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] limit;
    logic [VALUE_W-1:0] magnitude;

    assign limit     = byte_limit(value_size);
    assign magnitude = {acc_reg[VALUE_W-7:0], item.byte_value[5:0]};

    always_comb
    begin
        has_result    = 1'b0;
        result.value  = '0;
        result.status = STATUS_OK;
        acc_next      = acc_reg;
        count_next    = count_reg;
        if (item.buffer_end)
        begin
            // end between values is silent
            if (count_reg != '0)
            begin
                has_result    = 1'b1;
                result.status = STATUS_SHORT;
                acc_next      = '0;
                count_next    = '0;
            end
        end
        else if (count_reg >= limit)
        begin
            // offending byte is dropped
            has_result    = 1'b1;
            result.status = STATUS_TOO_LONG;
            acc_next      = '0;
            count_next    = '0;
        end
        else if (item.byte_value[7])
        begin
            has_result   = 1'b1;
            result.value = item.byte_value[6] ? (-magnitude) : magnitude;
            acc_next     = '0;
            count_next   = '0;
        end
        else
        begin
            acc_next   = {acc_reg[VALUE_W-8:0], item.byte_value[6:0]};
            count_next = count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/svd_checker.sv
// ----------------------------------------------------------------------------
// svd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module svd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  svd_pkg::svd_out_t          out_data,
    input  logic                       pready
);
    import svd_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_SHORT
                       || out_data.status == STATUS_TOO_LONG))
        else $error("unknown status code");

    // error results carry a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_OK |-> out_data.value == '0)
        else $error("error result with non-zero value");

    // a fresh result follows an accepted input beat, through the input and result registers
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a preceding input beat");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind signed_varint_decoder svd_checker u_svd_checker (.*);
